>>> src/bdhs_pkg.sv
package bdhs_pkg;

    localparam int unsigned TICK_W = 32;
    localparam int unsigned PORT_W = 8;
    localparam int unsigned BIT_SEL_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK = 2'd3;

    // Reset values of the registers
    localparam logic [BIT_SEL_W-1:0] RST_INPUT_BIT = 3'd0;
    localparam logic [TICK_W-1:0] RST_DEBOUNCE = 32'd50;
    localparam logic [TICK_W-1:0] RST_HOLD = 32'd100;
    localparam logic [TICK_W-1:0] RST_STUCK = 32'd2000;

    typedef struct packed {
        logic [PORT_W-1:0] port_value;
        logic [TICK_W-1:0] now;
    } t_in_beat;

    typedef struct packed {
        logic toggle;
        logic pressed_seen;
        logic latched;
        logic hold;
        logic stuck;
    } t_out_beat;

    typedef struct packed {
        logic [BIT_SEL_W-1:0] input_bit;
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] hold_ticks;
        logic [TICK_W-1:0] stuck_ticks;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic seen;
        logic toggle;
        logic hold;
        logic stuck;
        logic [TICK_W-1:0] stamp;
    } t_btn_state;

endpackage

>>> src/bdhs_step.sv
module bdhs_step (
    input  bdhs_pkg::t_cfg       i_cfg,
    input  bdhs_pkg::t_btn_state i_state,
    input  bdhs_pkg::t_in_beat   i_beat,
    output bdhs_pkg::t_btn_state o_state
);
    import bdhs_pkg::*;

    logic              pressed;
    logic [TICK_W-1:0] elapsed;
    logic              over_deb;
    logic              over_hold;
    logic              over_stuck;
    logic              ev_press;
    logic              ev_release;
    logic              ev_hold;
    logic              ev_stuck;

    // A press resets elapsed to zero, so hold and stuck cannot fire on the
    // same poll; all four events are therefore taken from the old state.
    assign pressed    = ~i_beat.port_value[i_cfg.input_bit];
    assign elapsed    = i_beat.now - i_state.stamp;
    assign over_deb   = elapsed > i_cfg.debounce_ticks;
    assign over_hold  = elapsed > i_cfg.hold_ticks;
    assign over_stuck = elapsed > i_cfg.stuck_ticks;

    assign ev_press   = pressed & ~i_state.latch & over_deb;
    assign ev_release = ~pressed & i_state.latch & over_deb;
    assign ev_hold    = pressed & i_state.latch & over_hold & ~over_stuck;
    assign ev_stuck   = pressed & i_state.latch & over_stuck;

    always_comb begin
        o_state        = i_state;
        o_state.toggle = i_state.toggle ^ (ev_press | ev_hold | ev_stuck);
        o_state.seen   = i_state.seen | ev_press;
        if (ev_press) begin
            o_state.latch = 1'b1;
            o_state.stamp = i_beat.now;
        end
        if (ev_release) begin
            o_state.latch = 1'b0;
            o_state.hold  = 1'b0;
            o_state.stuck = 1'b0;
            o_state.stamp = i_beat.now;
        end
        if (ev_hold) begin
            o_state.hold = 1'b1;
        end
        if (ev_stuck) begin
            o_state.hold  = 1'b0;
            o_state.stuck = 1'b1;
        end
    end

endmodule

>>> src/button_debounce_hold_stuck.sv
// Button debounce with toggle, long-press (hold) and stuck detection.
//
// Input channel: one beat per poll, the sampled port byte and the current
// value of a free-running 32-bit tick counter. The selected port bit is low
// while the button is pressed. Output channel: one beat per poll carrying
// toggle, pressed_seen, latched, hold and stuck as they stand after it.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low.
//
// From input accept to output valid: one input register, then the step logic
// (one 32-bit subtract and three compares) feeding the state and output
// registers. Throughput is one poll per clock unless the output stalls.
//
// Configuration: write enable, 2-bit index, 32-bit data; the user writes
// only when idle, unchecked. Indexes: input_bit, debounce/hold/stuck_ticks.
//
// Reset (synchronous, active low) clears all flags and the stamp, loads the
// register defaults and empties both stages. A stalled output freezes the
// output register and the input stage; input stall rises only when the
// input stage is full and cannot move on.
module button_debounce_hold_stuck (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [bdhs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bdhs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  bdhs_pkg::t_in_beat                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output bdhs_pkg::t_out_beat                  o_out_data
);
    import bdhs_pkg::*;

    t_cfg       r_cfg;
    t_btn_state r_st;
    t_btn_state n_st;
    t_in_beat   r_in;
    logic       r_in_vld;
    t_out_beat  r_out;
    logic       r_out_vld;

    logic       adv;    // output stage can take a new beat
    logic       in_acc;
    logic       fire;   // step logic commits this cycle

    assign adv    = ~r_out_vld | ~i_out_stall;
    assign fire   = r_in_vld & adv;
    assign o_in_stall = r_in_vld & ~adv;
    assign in_acc = i_in_valid & ~o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_bit      <= RST_INPUT_BIT;
            r_cfg.debounce_ticks <= RST_DEBOUNCE;
            r_cfg.hold_ticks     <= RST_HOLD;
            r_cfg.stuck_ticks    <= RST_STUCK;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_INPUT_BIT: r_cfg.input_bit      <= i_cfg_data[BIT_SEL_W-1:0];
                CFG_DEBOUNCE:  r_cfg.debounce_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_HOLD:      r_cfg.hold_ticks     <= i_cfg_data[TICK_W-1:0];
                CFG_STUCK:     r_cfg.stuck_ticks    <= i_cfg_data[TICK_W-1:0];
            endcase
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (adv | ~r_in_vld) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    bdhs_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_st),
        .i_beat  (r_in),
        .o_state (n_st)
    );

    // Button state: updated once per poll as it leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (fire) begin
            r_st <= n_st;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.toggle       <= n_st.toggle;
            r_out.pressed_seen <= n_st.seen;
            r_out.latched      <= n_st.latch;
            r_out.hold         <= n_st.hold;
            r_out.stuck        <= n_st.stuck;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // a stalled output beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output beat changed");

    // hold or stuck only while a press is latched
    a_hold_needs_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.hold || r_st.stuck) |-> r_st.latch)
        else $error("hold/stuck without latch");

    // pressed_seen is sticky once set
    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.seen |=> r_st.seen)
        else $error("pressed_seen cleared");

    // state only moves when a poll commits
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_st))
        else $error("state changed without a poll");

    // a committed poll always shows up at the output
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("poll lost on the way out");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    import bdhs_pkg::*;

    // Directed poll: port byte, tick value, and a hand-worked flag set where
    // one is obvious from the rules (known = 1); other rows use the predictor.
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [TICK_W-1:0] now;
        logic              known;
        logic [4:0]        flags;   // toggle, seen, latched, hold, stuck
    } t_poll_row;

    // One random segment: register words, poll count and starting tick.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] bit_word;
        logic [TICK_W-1:0]     deb;
        logic [TICK_W-1:0]     hld;
        logic [TICK_W-1:0]     stk;
        logic [31:0]           n_polls;
        logic [TICK_W-1:0]     t0;
    } t_segment;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_beat              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_beat             o_out_data;

    button_debounce_hold_stuck dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 8 ns period
    always #4 i_clk = ~i_clk;

    // Predictor copy of the button state and the registers
    t_btn_state btn;
    t_cfg       btn_cfg;

    // Flag sets still owed by the block, oldest first
    t_out_beat  flags_due[$];

    int unsigned n_bad = 0;
    int unsigned n_seen = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // Stimulus generator state: where the simulated tick counter stands and
    // whether the "finger" is currently on the button.
    logic [TICK_W-1:0] t_now = '0;
    logic              finger_down = 1'b0;

    // Directed polls, run with the reset register values
    // (bit 0, debounce 50, hold 100, stuck 2000).
    t_poll_row dir_polls [16] = '{
        '{8'hFF, 32'd0,          1'b1, 5'b00000},  // idle after reset
        '{8'hFE, 32'd10,         1'b1, 5'b00000},  // press inside debounce
        '{8'h00, 32'd51,         1'b1, 5'b11100},  // first accepted press
        '{8'hFE, 32'd151,        1'b0, 5'b00000},  // hold edge, not past it
        '{8'hFE, 32'd152,        1'b1, 5'b01110},  // into hold window
        '{8'hFE, 32'd2051,       1'b0, 5'b00000},  // last poll of hold window
        '{8'hFE, 32'd2052,       1'b1, 5'b01101},  // past stuck delay
        '{8'h01, 32'd2080,       1'b1, 5'b01000},  // release clears hold/stuck
        '{8'hFE, 32'd2100,       1'b0, 5'b00000},  // press too soon
        '{8'hFE, 32'd2131,       1'b0, 5'b00000},  // press accepted
        '{8'hFF, 32'd2150,       1'b0, 5'b00000},  // release too soon
        '{8'hFF, 32'hFFFF_FFF0,  1'b0, 5'b00000},  // release near counter top
        '{8'hFE, 32'h0000_0030,  1'b0, 5'b00000},  // press across the wrap
        '{8'h80, 32'h0000_0095,  1'b0, 5'b00000},  // hold after the wrap
        '{8'hAA, 32'hFFFF_FFFF,  1'b0, 5'b00000},  // max tick, stuck
        '{8'h55, 32'hFFFF_FFFF,  1'b0, 5'b00000}   // release at max tick
    };

    // Random segments. The first two run with a slow receiver, the next two
    // with a slow sender, the last two with no idling at all.
    t_segment segs [6] = '{
        '{32'd3,         32'd5,         32'd20,        32'd60,
          32'd130, 32'd0},
        // all thresholds at zero: every held poll is stuck at once
        '{32'd7,         32'd0,         32'd0,         32'd0,
          32'd130, 32'h0000_1000},
        // upper bits of the bit select dropped (selects bit 2); widest
        // possible hold window; debounce one below the top
        '{32'hFFFF_FFFA, 32'hFFFF_FFFE, 32'd0,         32'hFFFF_FFFF,
          32'd120, 32'h8000_0000},
        // debounce can never be exceeded: the button never latches
        '{32'd6,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7,
          32'd40,  32'd5},
        // hold delay above stuck delay: empty hold window
        '{32'd5,         32'd10,        32'd200,       32'd100,
          32'd130, 32'h0001_0000},
        // start just below the counter top so polls wrap around
        '{32'd1,         32'd3,         32'd30,        32'd90,
          32'd150, 32'hFFFF_FF00}
    };

    // Predicts the flags after one poll and advances the model state.
    // Each rule sees what the one before it left behind.
    function automatic t_out_beat debounce_poll(input t_in_beat b);
        logic              pressed;
        logic [TICK_W-1:0] since;
        t_out_beat         r;
        pressed = (b.port_value[btn_cfg.input_bit] == 1'b0);

        since = b.now - btn.stamp;
        if (pressed && !btn.latch && since > btn_cfg.debounce_ticks) begin
            btn.toggle = !btn.toggle;
            btn.latch  = 1'b1;
            btn.stamp  = b.now;
            btn.seen   = 1'b1;
        end

        since = b.now - btn.stamp;
        if (!pressed && btn.latch && since > btn_cfg.debounce_ticks) begin
            btn.latch = 1'b0;
            btn.hold  = 1'b0;
            btn.stuck = 1'b0;
            btn.stamp = b.now;
        end

        since = b.now - btn.stamp;
        if (pressed && btn.latch && since > btn_cfg.hold_ticks
                && since <= btn_cfg.stuck_ticks) begin
            btn.hold   = 1'b1;
            btn.toggle = !btn.toggle;
        end

        since = b.now - btn.stamp;
        if (pressed && btn.latch && since > btn_cfg.stuck_ticks) begin
            btn.hold   = 1'b0;
            btn.stuck  = 1'b1;
            btn.toggle = !btn.toggle;
        end

        r.toggle       = btn.toggle;
        r.pressed_seen = btn.seen;
        r.latched      = btn.latch;
        r.hold         = btn.hold;
        r.stuck        = btn.stuck;
        return r;
    endfunction

    // Random poll. Mostly a plausible finger: long presses and releases with
    // some contact bounce. Tick steps are often aimed right at the debounce,
    // hold and stuck boundaries (one below, on, one above) measured from the
    // current stamp; now and then the tick or the whole port byte is noise.
    function automatic t_in_beat make_poll();
        t_in_beat          b;
        logic              lvl;
        logic [TICK_W-1:0] nudge;
        if ($urandom_range(0, 9) == 0)
            finger_down = !finger_down;
        nudge = 32'($urandom_range(0, 2)) - 32'd1;
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6: t_now = t_now + 32'($urandom_range(0, 3));
            7, 8:   t_now = btn.stamp + btn_cfg.debounce_ticks + nudge;
            9, 10:  t_now = btn.stamp + btn_cfg.hold_ticks + nudge;
            11, 12: t_now = btn.stamp + btn_cfg.stuck_ticks + nudge;
            13:     t_now = $urandom();
            default: t_now = t_now + 32'($urandom_range(1, 150));
        endcase
        b.now = t_now;
        b.port_value = 8'($urandom());
        lvl = !finger_down;                     // pin reads low while pressed
        if ($urandom_range(0, 99) < 15)
            lvl = !lvl;                         // bounce
        if ($urandom_range(0, 99) >= 8)
            b.port_value[btn_cfg.input_bit] = lvl;
        return b;
    endfunction

    task automatic flag_error(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        n_bad++;
    endtask

    // Offer one beat, with random idle cycles in front of it, and hold it
    // until taken. Called and left at a falling edge.
    task automatic drive_poll(input t_in_beat b, input logic known,
                              input t_out_beat fixed);
        t_out_beat want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        want = debounce_poll(b);
        flags_due.push_back(known ? fixed : want);
        @(negedge i_clk);
    endtask

    // Writes all four registers, one per cycle, and mirrors them.
    task automatic load_regs(input t_segment s);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= CFG_INPUT_BIT;
        i_cfg_data  <= s.bit_word;
        btn_cfg.input_bit = s.bit_word[BIT_SEL_W-1:0];
        @(negedge i_clk);
        i_cfg_idx  <= CFG_DEBOUNCE;
        i_cfg_data <= s.deb;
        btn_cfg.debounce_ticks = s.deb;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_HOLD;
        i_cfg_data <= s.hld;
        btn_cfg.hold_ticks = s.hld;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_STUCK;
        i_cfg_data <= s.stk;
        btn_cfg.stuck_ticks = s.stk;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait for every owed flag set, then a few cycles more (two-stage pipe).
    task automatic drain();
        while (flags_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Receiver: random stall, new decision every cycle
    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Output checker: each accepted beat against the oldest expectation
    always @(posedge i_clk) begin : check_flags
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (flags_due.size() == 0) begin
                flag_error($sformatf("unexpected output beat %b", o_out_data));
            end else begin
                want = flags_due.pop_front();
                if (o_out_data !== want)
                    flag_error($sformatf(
                        "poll %0d: toggle/seen/latched/hold/stuck = %b, want %b",
                        n_seen, o_out_data, want));
            end
            n_seen++;
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        btn = '0;
        btn_cfg.input_bit      = RST_INPUT_BIT;
        btn_cfg.debounce_ticks = RST_DEBOUNCE;
        btn_cfg.hold_ticks     = RST_HOLD;
        btn_cfg.stuck_ticks    = RST_STUCK;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct  = 36;
        recv_stall_pct = 88;
        @(negedge i_clk);

        // Directed part on reset register values
        foreach (dir_polls[k]) begin
            drive_poll({dir_polls[k].port, dir_polls[k].now},
                       dir_polls[k].known, t_out_beat'(dir_polls[k].flags));
        end
        i_in_valid <= 1'b0;
        drain();

        // Random part, one register setting per segment
        foreach (segs[s]) begin
            case (s / 2)
                0: begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 88;
                end
                1: begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 36;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            load_regs(segs[s]);
            t_now = segs[s].t0;
            for (int unsigned n = 0; n < segs[s].n_polls; n++)
                drive_poll(make_poll(), 1'b0, '0);
            i_in_valid <= 1'b0;
            drain();
        end

        repeat (8) @(negedge i_clk);
        if (n_bad == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
